// ===== rtl/cblt_pkg.sv =====
// Package for the cell bucket list table: sizes, command codes, item types and
// the request/response structs between the controller and the two memories.
// No dependencies.
`default_nettype none

package cblt_pkg;

    localparam int POOL_DEPTH = 64;
    localparam int CELL_COUNT = 64;
    localparam int RESULT_CAP = 64;

    localparam int NODE_W   = $clog2(POOL_DEPTH);
    localparam int CELL_W   = $clog2(CELL_COUNT);
    localparam int CNT_W    = $clog2(RESULT_CAP);
    localparam int MEMBER_W = 6;
    localparam int CMD_W    = 2;
    localparam int CIDX_W   = 6;
    localparam int LIMIT_W  = 7;
    localparam int LIM_CMP_W = (LIMIT_W > NODE_W + 1) ? LIMIT_W : NODE_W + 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);
    localparam logic [CNT_W-1:0]   COUNT_MAX   = CNT_W'(RESULT_CAP - 1);

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [CIDX_W-1:0]   cell_index;
        logic [MEMBER_W-1:0] member_id;
    } t_in_item;

    typedef struct packed {
        logic [MEMBER_W-1:0] member_out;
        logic                cell_empty;
        logic                last;
        logic                out_of_space;
    } t_out_item;

    typedef struct packed {
        logic              rd_en;
        logic [CELL_W-1:0] rd_addr;
        logic              wr_en;
        logic [CELL_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_head;
        logic [NODE_W-1:0] wr_tail;
        logic              clr;
    } t_cell_req;

    typedef struct packed {
        logic              vld;
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
    } t_cell_rsp;

    typedef struct packed {
        logic                rd_en;
        logic [NODE_W-1:0]   rd_addr;
        logic                mbr_wr_en;
        logic [NODE_W-1:0]   mbr_wr_addr;
        logic [MEMBER_W-1:0] mbr_wr_data;
        logic                lnk_wr_en;
        logic [NODE_W-1:0]   lnk_wr_addr;
        logic [NODE_W-1:0]   lnk_wr_data;
    } t_node_req;

    typedef struct packed {
        logic [MEMBER_W-1:0] member;
        logic [NODE_W-1:0]   link;
    } t_node_rsp;

endpackage

`default_nettype wire

// ===== rtl/cblt_cell_mem.sv =====
// Per-cell head/tail pointer memory with one valid flop per cell.
// Depends on cblt_pkg.
`default_nettype none

module cblt_cell_mem (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire cblt_pkg::t_cell_req i_req,
    output cblt_pkg::t_cell_rsp     o_rsp
);
    import cblt_pkg::*;

    logic [NODE_W-1:0]     r_head_mem [CELL_COUNT];
    logic [NODE_W-1:0]     r_tail_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_vld;
    logic [NODE_W-1:0]     r_rsp_head;
    logic [NODE_W-1:0]     r_rsp_tail;
    logic                  r_rsp_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_head_mem[i_req.wr_addr] <= i_req.wr_head;
            r_tail_mem[i_req.wr_addr] <= i_req.wr_tail;
        end
        if (i_req.rd_en) begin
            r_rsp_head <= r_head_mem[i_req.rd_addr];
            r_rsp_tail <= r_tail_mem[i_req.rd_addr];
        end
    end

    // valid bits: a clear empties every cell together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rsp_vld <= 1'b0;
        end else begin
            if (i_req.clr) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rsp_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rsp = {r_rsp_vld, r_rsp_head, r_rsp_tail};

endmodule

`default_nettype wire

// ===== rtl/cblt_node_mem.sv =====
// Node pool memories: member id and forward link of each pool node.
// Depends on cblt_pkg.
`default_nettype none

module cblt_node_mem (
    input  wire logic               i_clk,
    input  wire cblt_pkg::t_node_req i_req,
    output cblt_pkg::t_node_rsp     o_rsp
);
    import cblt_pkg::*;

    logic [MEMBER_W-1:0] r_mbr_mem [POOL_DEPTH];
    logic [NODE_W-1:0]   r_lnk_mem [POOL_DEPTH];
    logic [MEMBER_W-1:0] r_rsp_member;
    logic [NODE_W-1:0]   r_rsp_link;

    always_ff @(posedge i_clk) begin
        if (i_req.mbr_wr_en) begin
            r_mbr_mem[i_req.mbr_wr_addr] <= i_req.mbr_wr_data;
        end
        if (i_req.rd_en) begin
            r_rsp_member <= r_mbr_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lnk_wr_en) begin
            r_lnk_mem[i_req.lnk_wr_addr] <= i_req.lnk_wr_data;
        end
        if (i_req.rd_en) begin
            r_rsp_link <= r_lnk_mem[i_req.rd_addr];
        end
    end

    assign o_rsp = {r_rsp_member, r_rsp_link};

endmodule

`default_nettype wire

// ===== rtl/cblt_ctrl.sv =====
// Command sequencer: accepts items, drives the cell and node memories,
// walks lists and owns the result register. Depends on cblt_pkg.
`default_nettype none

module cblt_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire cblt_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output cblt_pkg::t_out_item      o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [cblt_pkg::LIMIT_W-1:0] i_cfg_data,
    output cblt_pkg::t_cell_req      o_cell_req,
    input  wire cblt_pkg::t_cell_rsp i_cell_rsp,
    output cblt_pkg::t_node_req      o_node_req,
    input  wire cblt_pkg::t_node_rsp i_node_rsp
);
    import cblt_pkg::*;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [CELL_W-1:0]   r_cell, n_cell;
    logic [MEMBER_W-1:0] r_member, n_member;
    logic [NODE_W-1:0]   r_node, n_node;
    logic [NODE_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [NODE_W-1:0]   r_next_free, n_next_free;
    logic                r_exhausted, n_exhausted;
    logic [LIMIT_W-1:0]  r_limit;
    logic                r_out_vld, n_out_vld;
    t_out_item           r_out, n_out;

    logic                accept;
    logic                slot_free;
    logic                walk_last;
    logic                out_load;
    logic [LIM_CMP_W-1:0] lim_raw;
    logic [LIM_CMP_W-1:0] lim_eff;
    logic [LIM_CMP_W-1:0] node_inc;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign slot_free  = !r_out_vld || !i_out_stall;
    assign walk_last  = (r_node == r_tail) || (r_count == COUNT_MAX);

    // zero behaves as one, anything above the pool saturates
    assign lim_raw  = LIM_CMP_W'(r_limit);
    assign lim_eff  = (lim_raw == '0) ? LIM_CMP_W'(1) :
                      (lim_raw > LIM_CMP_W'(POOL_DEPTH)) ? LIM_CMP_W'(POOL_DEPTH) : lim_raw;
    assign node_inc = LIM_CMP_W'(r_next_free) + LIM_CMP_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in_data.cmd == CMD_CLEAR || i_in_data.cmd == CMD_ADD ||
                               i_in_data.cmd == CMD_LIST)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    if (r_cmd == CMD_LIST && i_cell_rsp.vld) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WALK: begin
                if (slot_free && walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cell_req  = '0;
        o_node_req  = '0;
        out_load    = 1'b0;
        n_out       = '0;
        n_cmd       = r_cmd;
        n_cell      = r_cell;
        n_member    = r_member;
        n_node      = r_node;
        n_tail      = r_tail;
        n_count     = r_count;
        n_next_free = r_next_free;
        n_exhausted = r_exhausted;
        case (r_state)
            ST_IDLE: begin
                // start the cell read in the transfer cycle
                o_cell_req.rd_en   = accept;
                o_cell_req.rd_addr = CELL_W'(i_in_data.cell_index);
                if (accept) begin
                    n_cmd    = i_in_data.cmd;
                    n_cell   = CELL_W'(i_in_data.cell_index);
                    n_member = i_in_data.member_id;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    case (r_cmd)
                        CMD_CLEAR: begin
                            o_cell_req.clr = 1'b1;
                            n_next_free    = '0;
                            n_exhausted    = 1'b0;
                            out_load       = 1'b1;
                            n_out.last     = 1'b1;
                        end
                        CMD_ADD: begin
                            out_load   = 1'b1;
                            n_out.last = 1'b1;
                            if (r_exhausted) begin
                                n_out.out_of_space = 1'b1;
                            end else begin
                                o_cell_req.wr_en   = 1'b1;
                                o_cell_req.wr_addr = r_cell;
                                o_cell_req.wr_head = i_cell_rsp.vld ? i_cell_rsp.head
                                                                    : r_next_free;
                                o_cell_req.wr_tail = r_next_free;
                                o_node_req.mbr_wr_en   = 1'b1;
                                o_node_req.mbr_wr_addr = r_next_free;
                                o_node_req.mbr_wr_data = r_member;
                                // chain the old tail to the new node
                                o_node_req.lnk_wr_en   = i_cell_rsp.vld;
                                o_node_req.lnk_wr_addr = i_cell_rsp.tail;
                                o_node_req.lnk_wr_data = r_next_free;
                                if (node_inc < lim_eff) begin
                                    n_next_free = r_next_free + NODE_W'(1);
                                end else begin
                                    n_exhausted = 1'b1;
                                end
                            end
                        end
                        CMD_LIST: begin
                            if (i_cell_rsp.vld) begin
                                o_node_req.rd_en   = 1'b1;
                                o_node_req.rd_addr = i_cell_rsp.head;
                                n_node  = i_cell_rsp.head;
                                n_tail  = i_cell_rsp.tail;
                                n_count = '0;
                            end else begin
                                out_load         = 1'b1;
                                n_out.cell_empty = 1'b1;
                                n_out.last       = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (slot_free) begin
                    out_load         = 1'b1;
                    n_out.member_out = i_node_rsp.member;
                    n_out.last       = walk_last;
                    if (!walk_last) begin
                        o_node_req.rd_en   = 1'b1;
                        o_node_req.rd_addr = i_node_rsp.link;
                        n_node  = i_node_rsp.link;
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_free <= '0;
            r_exhausted <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_exhausted <= n_exhausted;
            r_out_vld   <= n_out_vld;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_cell   <= n_cell;
        r_member <= n_member;
        r_node   <= n_node;
        r_tail   <= n_tail;
        r_count  <= n_count;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/cell_bucket_list_table_unit.sv =====
// Top level of the cell bucket list table.
// Uses cblt_pkg, cblt_ctrl, cblt_cell_mem and cblt_node_mem.
//
// Input channel: i_in_valid / o_in_stall / i_in_data carry one command
// (clear, add, list) per transfer. Output channel: o_out_valid / i_out_stall
// / o_out_data carry result items; the item that ends a command has last set.
// Configuration: i_cfg_we writes i_cfg_data into the pool limit register
// (reset value 64); write it only while the block is idle.
// Timing: the cell pointer memory is read in the transfer cycle. Clear and add
// load their single result in the execute state, once the output register is
// free. A list reads the node memory along the chain, one member per cycle
// while the output is free; an empty cell gives a single cell_empty result.
// Unused command code 3 is dropped in its transfer cycle with no result.
// A result waits in the output register while the receiver stalls; the next
// command may be taken meanwhile, but no new result is loaded until the
// register drains. Reset (synchronous, active low) empties all cells,
// rewinds the pool and restores the limit; no clearing sweep is needed.
`default_nettype none

module cell_bucket_list_table_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire cblt_pkg::t_in_item            i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output cblt_pkg::t_out_item                o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [cblt_pkg::LIMIT_W-1:0]  i_cfg_data
);
    import cblt_pkg::*;

    t_cell_req cell_req;
    t_cell_rsp cell_rsp;
    t_node_req node_req;
    t_node_rsp node_rsp;

    cblt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_cell_req  (cell_req),
        .i_cell_rsp  (cell_rsp),
        .o_node_req  (node_req),
        .i_node_rsp  (node_rsp)
    );

    cblt_cell_mem u_cell_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cell_req),
        .o_rsp   (cell_rsp)
    );

    cblt_node_mem u_node_mem (
        .i_clk (i_clk),
        .i_req (node_req),
        .o_rsp (node_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/cblt_checker.sv =====
// Port-level checks for the cell bucket list table, bound to the top level.
// Depends on cblt_pkg and cell_bucket_list_table_unit.
`default_nettype none

module cblt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire cblt_pkg::t_in_item            i_in_data,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire cblt_pkg::t_out_item           o_out_data
);
    import cblt_pkg::*;

    // a real command holds the input side off while it runs
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_in_data.cmd == CMD_CLEAR || i_in_data.cmd == CMD_ADD ||
          i_in_data.cmd == CMD_LIST)) |=> o_in_stall)
        else $error("input not held off after a command transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.cell_empty) |->
        (o_out_data.last && o_out_data.member_out == '0 && !o_out_data.out_of_space))
        else $error("empty-cell result malformed");

    a_oos_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_space) |->
        (o_out_data.last && !o_out_data.cell_empty && o_out_data.member_out == '0))
        else $error("out-of-space result malformed");

endmodule

bind cell_bucket_list_table_unit cblt_checker u_cblt_checker (.*);

`default_nettype wire
